// ----- hw/rtl/svmd_pkg.sv -----
// ----------------------------------------------------------------------------
// svmd_pkg: shared definitions for the seven-segment display scan driver
// Beat types, field widths, decimal split constants and the segment table.
// ----------------------------------------------------------------------------
package svmd_pkg;

  localparam int NUM_DIGITS = 4;

  localparam int VALUE_W  = 14;
  localparam int SEG_W    = 8;
  localparam int PERIOD_W = 16;
  localparam int OUT_EN_W  = 4;
  localparam int OUT_IDX_W = 2;

  localparam int SCAN_W      = $clog2(NUM_DIGITS);
  localparam int EN_FULL_W   = (NUM_DIGITS > OUT_EN_W) ? NUM_DIGITS : OUT_EN_W;
  localparam int IDX_FULL_W  = (SCAN_W > OUT_IDX_W) ? SCAN_W : OUT_IDX_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;

  localparam int               POINT_DIGIT = 1;
  localparam logic [SEG_W-1:0] POINT_MASK  = 8'h01;

  localparam longint unsigned POW10 [0:8] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000
  };

  localparam longint unsigned VALUE_MAX   = (64'd1 << VALUE_W) - 64'd1;
  localparam longint unsigned DISPLAY_MAX = POW10[NUM_DIGITS] - 64'd1;

  // Largest value the display can show, clipped to the field range. When the
  // display can show every field value, the compare against it never fires.
  localparam logic [VALUE_W-1:0] SAT_LIMIT =
    (DISPLAY_MAX < VALUE_MAX) ? VALUE_W'(DISPLAY_MAX) : VALUE_W'(VALUE_MAX);

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] centi_value;
    logic               show_point;
  } svmd_in_t;

  typedef struct packed {
    logic [OUT_EN_W-1:0]  digit_enable_n;
    logic [SEG_W-1:0]     segment_byte;
    logic [OUT_IDX_W-1:0] digit_index;
  } svmd_out_t;

  // Quotients of the value by successive powers of ten, quot[0] being the
  // value itself.
  typedef struct packed {
    logic                                cmd;
    logic                                show_point;
    logic                                saturate;
    logic [NUM_DIGITS-1:0][VALUE_W-1:0]  quot;
  } svmd_split_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'b11111100;
      4'd1:    code = 8'b01100000;
      4'd2:    code = 8'b11011010;
      4'd3:    code = 8'b11110010;
      4'd4:    code = 8'b01100110;
      4'd5:    code = 8'b10110110;
      4'd6:    code = 8'b10111110;
      4'd7:    code = 8'b11100000;
      4'd8:    code = 8'b11111110;
      4'd9:    code = 8'b11110110;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/seven_segment_mux_driver.sv -----
// ----------------------------------------------------------------------------
// seven_segment_mux_driver: multiplexed seven-segment display scan driver
// Splits a value in hundredths into decimal digit codes and, paced by timer
// ticks, emits one digit refresh beat at a time for a shift-out stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): a load beat (cmd 0) stores
//   a new value, saturated to the all-nines value, with an optional point on
//   the second digit. A tick beat (cmd 1) advances the refresh divider.
//   Output channel (out_valid / out_stall / out_data): one beat per refresh,
//   carrying the active-low digit enable, the segment byte (MSB first, then
//   latch) and the digit index.
//   Config channel (cfg_valid / cfg_ready / cfg_data): refresh_period, ticks
//   minus one between refreshes; cfg_ready is always high.
// Timing: one beat is taken every cycle unless in_stall is high. A refreshing
//   tick passes from the input register through the quotient register to the
//   result register, which raises out_valid.
// Reset: the store is blank, divider and scan position are zero and the
//   period returns to 999. No beat is pending on either side.
// Stall: the result register holds under out_stall; loads and ticks that do
//   not refresh keep flowing, and in_stall rises only when a refreshing tick
//   finds the result register still occupied.
// ----------------------------------------------------------------------------
module seven_segment_mux_driver
  import svmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  svmd_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output svmd_out_t           out_data
);

  logic        hold;
  logic        s2_valid;
  svmd_split_t s2_data;

  svmd_split u_split (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .hold     (hold),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  svmd_refresh u_refresh (
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/svmd_split.sv -----
// ----------------------------------------------------------------------------
// svmd_split: input register and decimal quotient stage
// Registers the incoming beat, divides the value by each power of ten with a
// reciprocal multiply and registers the quotients for the refresh stage.
// ----------------------------------------------------------------------------
module svmd_split
  import svmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  svmd_in_t    in_data,
  input  logic        hold,
  output logic        s2_valid,
  output svmd_split_t s2_data
);

  logic        s1_valid;
  svmd_in_t    s1_data;
  logic        s2_load;
  logic        in_accept;
  logic [NUM_DIGITS-1:0][VALUE_W-1:0] quot;

  assign s2_load   = !s2_valid || !hold;
  assign in_stall  = s1_valid && !s2_load;
  assign in_accept = in_valid && !in_stall;

  assign quot[0] = s1_data.centi_value;

  // Exact for every field value: shift is the field width plus the bits of
  // the divisor, multiplier rounded up.
  for (genvar p = 1; p < NUM_DIGITS; p++) begin : g_quot
    localparam longint unsigned DIV = POW10[p];
    if (DIV > VALUE_MAX) begin : g_zero
      assign quot[p] = '0;
    end else begin : g_recip
      localparam int              SHIFT  = VALUE_W + $clog2(DIV);
      localparam longint unsigned MULT   = ((64'd1 << SHIFT) / DIV) + 64'd1;
      localparam int              MULT_W = VALUE_W + 2;
      localparam int              PROD_W = VALUE_W + MULT_W;
      logic [PROD_W-1:0] prod;
      assign prod    = PROD_W'(s1_data.centi_value) * PROD_W'(MULT);
      assign quot[p] = VALUE_W'(prod >> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= in_data;
    end
    if (s2_load) begin
      s2_data.cmd        <= s1_data.cmd;
      s2_data.show_point <= s1_data.show_point;
      s2_data.saturate   <= s1_data.centi_value > SAT_LIMIT;
      s2_data.quot       <= quot;
    end
  end

endmodule

// ----- hw/rtl/svmd_refresh.sv -----
// ----------------------------------------------------------------------------
// svmd_refresh: segment store, refresh divider and result register
// Turns quotients into segment codes on a load, counts ticks and emits one
// refresh beat per period, stepping through the digits.
// ----------------------------------------------------------------------------
module svmd_refresh
  import svmd_pkg::*;
(
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                clk,
  input  logic                rst,
  input  logic                s2_valid,
  input  svmd_split_t         s2_data,
  output logic                hold,
  output logic                out_valid,
  input  logic                out_stall,
  output svmd_out_t           out_data
);

  logic [PERIOD_W-1:0] refresh_period;
  logic [PERIOD_W-1:0] refresh_count;
  logic [SCAN_W-1:0]   scan_position;
  logic [SCAN_W-1:0]   scan_position_next;
  logic [SEG_W-1:0]    segment_store [NUM_DIGITS];
  logic [SEG_W-1:0]    load_code [NUM_DIGITS];
  logic                fire;
  logic                retire;
  logic [EN_FULL_W-1:0]  enable_full;
  logic [IDX_FULL_W-1:0] index_full;

  assign cfg_ready = 1'b1;

  assign fire   = (s2_data.cmd == CMD_TICK) && (refresh_count >= refresh_period);
  assign hold   = s2_valid && fire && out_valid && out_stall;
  assign retire = s2_valid && !hold;

  assign scan_position_next = (scan_position == SCAN_W'(NUM_DIGITS - 1)) ?
                              '0 : scan_position + SCAN_W'(1);

  assign enable_full = ~(EN_FULL_W'(1) << scan_position);
  assign index_full  = IDX_FULL_W'(scan_position);

  // Digit of weight 10^p is quot[p] minus ten times quot[p+1]; the store
  // keeps the most significant digit at entry zero.
  always_comb begin
    logic [VALUE_W-1:0] upper;
    logic [VALUE_W-1:0] diff;
    logic [3:0]         digit;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      upper = (p + 1 < NUM_DIGITS) ? s2_data.quot[(p + 1) % NUM_DIGITS] : '0;
      diff  = s2_data.quot[p] - (upper << 3) - (upper << 1);
      digit = s2_data.saturate ? 4'd9 : diff[3:0];
      load_code[NUM_DIGITS - 1 - p] = seg_code(digit);
    end
    if (s2_data.show_point && (POINT_DIGIT < NUM_DIGITS)) begin
      load_code[POINT_DIGIT] = load_code[POINT_DIGIT] | POINT_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= PERIOD_RESET;
      refresh_count  <= '0;
      scan_position  <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        segment_store[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        refresh_period <= cfg_data;
      end
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (retire) begin
        if (s2_data.cmd == CMD_LOAD) begin
          segment_store <= load_code;
        end else if (fire) begin
          refresh_count <= '0;
          scan_position <= scan_position_next;
          out_valid     <= 1'b1;
        end else begin
          refresh_count <= refresh_count + PERIOD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && (s2_data.cmd == CMD_TICK) && fire) begin
      out_data.digit_enable_n <= enable_full[OUT_EN_W-1:0];
      out_data.segment_byte   <= segment_store[scan_position];
      out_data.digit_index    <= index_full[OUT_IDX_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/svmd_checker.sv -----
// ----------------------------------------------------------------------------
// svmd_assert: port-level checks for the display scan driver
// Watches the top level's ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module svmd_assert
  import svmd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [PERIOD_W-1:0] cfg_data,
  input logic                in_valid,
  input logic                in_stall,
  input svmd_in_t            in_data,
  input logic                out_valid,
  input logic                out_stall,
  input svmd_out_t           out_data
);

  // A refresh beat held by the receiver keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("refresh beat changed while stalled");

  // The enable pattern must select exactly the digit named by the index.
  a_enable_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && (NUM_DIGITS <= OUT_EN_W) |->
      out_data.digit_enable_n == ~(OUT_EN_W'(1) << out_data.digit_index))
    else $error("digit enable does not match digit index");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("refresh beat pending after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> !in_stall && cfg_ready)
    else $error("input side not open after reset");

endmodule

bind seven_segment_mux_driver svmd_assert u_svmd_assert (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/svmd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svmd_checker: scoreboard for the seven-segment scan driver
// Mirrors the digit store, refresh divider and scan position from every
// accepted load, tick and config beat. It queues the refresh beat that each
// tick should produce and compares it, field by field, with every beat taken
// from the output channel.
// ----------------------------------------------------------------------------
module svmd_checker
  import svmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  svmd_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  svmd_out_t           out_data,
  output int                  errors,
  output int                  backlog,
  output int                  beats_checked
);

  // Segment patterns for the digits 9 down to 0, digit 0 in the low byte.
  localparam logic [10*SEG_W-1:0] GLYPHS = {
    8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  logic [SEG_W-1:0]    shown [NUM_DIGITS];
  int                  scan_pos;
  logic [PERIOD_W-1:0] div_count;
  logic [PERIOD_W-1:0] period;
  svmd_out_t           refresh_due [$];

  initial begin
    errors = 0;
    backlog = 0;
    beats_checked = 0;
  end

  task automatic load_digits(input logic [VALUE_W-1:0] centi, input logic point);
    int unsigned v;
    int unsigned all_nines;
    all_nines = 1;
    for (int i = 0; i < NUM_DIGITS; i++) all_nines = all_nines * 10;
    all_nines = all_nines - 1;
    v = centi;
    if (v > all_nines) v = all_nines;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      shown[i] = GLYPHS[(v % 10) * SEG_W +: SEG_W];
      v = v / 10;
    end
    if (point && POINT_DIGIT < NUM_DIGITS) begin
      shown[POINT_DIGIT] = shown[POINT_DIGIT] | POINT_MASK;
    end
  endtask

  task automatic take_tick();
    svmd_out_t            beat;
    logic [EN_FULL_W-1:0] sel;
    // A plain compare: a divider already past a lowered period refreshes now.
    if (div_count < period) begin
      div_count = div_count + 1'b1;
    end else begin
      div_count = '0;
      sel = '1;
      sel[scan_pos] = 1'b0;
      beat.digit_enable_n = sel[OUT_EN_W-1:0];
      beat.segment_byte   = shown[scan_pos];
      beat.digit_index    = OUT_IDX_W'(scan_pos);
      refresh_due.push_back(beat);
      scan_pos = (scan_pos + 1) % NUM_DIGITS;
    end
  endtask

  task automatic check_beat(input svmd_out_t got);
    svmd_out_t want;
    if (refresh_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: refresh beat with none expected: enable_n %b segments %b index %0d",
                 $time, got.digit_enable_n, got.segment_byte, got.digit_index);
      end
    end else begin
      want = refresh_due.pop_front();
      beats_checked++;
      if (got.digit_enable_n !== want.digit_enable_n ||
          got.segment_byte !== want.segment_byte ||
          got.digit_index !== want.digit_index) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: refresh beat mismatch (expected/actual): enable_n %b/%b",
                   $time, want.digit_enable_n, got.digit_enable_n);
          $display("  segments %b/%b index %0d/%0d", want.segment_byte,
                   got.segment_byte, want.digit_index, got.digit_index);
        end
      end
    end
  endtask

  // Everything is driven on the rising edge, so the values seen at the
  // falling edge are exactly the ones the next rising edge will take.
  always @(negedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) shown[i] = '0;
      scan_pos = 0;
      div_count = '0;
      period = PERIOD_RESET;
      refresh_due.delete();
    end else begin
      if (out_valid && !out_stall) check_beat(out_data);
      if (cfg_valid && cfg_ready) period = cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_TICK) begin
          take_tick();
        end else begin
          load_digits(in_data.centi_value, in_data.show_point);
        end
      end
    end
    backlog = refresh_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the seven-segment scan driver
// Drives load and tick beats with random gaps against a randomly stalling
// output side, across a series of refresh periods from zero to the largest,
// and lets the checker compare every refresh beat with its prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import svmd_pkg::*;

  localparam int CYCLE_LIMIT = 300_000;
  localparam int TAIL_CYCLES = 12;
  localparam int NUM_PHASES  = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  svmd_in_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  svmd_out_t           out_data;

  int   errors;
  int   backlog;
  int   beats_checked;
  int   cycles = 0;
  int   loads_sent = 0;
  int   ticks_sent = 0;
  int   periods_used = 0;
  logic calm = 1'b0;

  always #1 clk = ~clk;

  seven_segment_mux_driver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  svmd_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .errors        (errors),
    .backlog       (backlog),
    .beats_checked (beats_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d refresh beats outstanding",
               cycles, backlog);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output side: a random stall ahead of every refresh beat, none while calm.
  initial begin : drain
    int   hold;
    logic took;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic send_item(input svmd_in_t item);
    int   gap;
    logic stalled;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (item.cmd == CMD_TICK) ticks_sent++;
    else loads_sent++;
  endtask

  task automatic send_load(input int value, input logic point);
    svmd_in_t item;
    item.cmd         = CMD_LOAD;
    item.centi_value = VALUE_W'(value);
    item.show_point  = point;
    send_item(item);
  endtask

  task automatic send_ticks(input int count);
    svmd_in_t item;
    repeat (count) begin
      item.cmd         = CMD_TICK;
      item.centi_value = VALUE_W'($urandom);
      item.show_point  = 1'($urandom);
      send_item(item);
    end
  endtask

  // The period only changes with the pipeline drained: every refresh beat
  // delivered and any trailing non-refreshing tick given time to retire.
  task automatic set_period(input logic [PERIOD_W-1:0] value);
    logic ready;
    in_valid <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
    cfg_valid <= 1'b0;
    periods_used++;
  endtask

  function automatic svmd_in_t random_item(input int tick_pct);
    svmd_in_t item;
    item.cmd        = ($urandom_range(1, 100) <= tick_pct) ? CMD_TICK : CMD_LOAD;
    item.show_point = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       item.centi_value = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
      1:       item.centi_value = VALUE_W'($urandom_range(0, 9999));
      2:       item.centi_value = VALUE_W'($urandom_range(9990, 10010));
      default: item.centi_value = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return item;
  endfunction

  initial begin : stimulus
    logic [PERIOD_W-1:0] period;
    int                  count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A few ticks under the reset period, then period zero: the divider is
    // already past it, and the blank store shows on all four digits.
    send_ticks(3);
    set_period('0);
    send_ticks(4);
    // Saturation, boundaries and leading zeros, with and without the point.
    send_load((1 << VALUE_W) - 1, 1'b1);
    send_ticks(4);
    send_load(0, 1'b0);
    send_ticks(1);
    send_load(10000, 1'b1);
    send_ticks(1);
    send_load(9999, 1'b0);
    send_ticks(2);
    send_load(8765, 1'b1);
    send_ticks(1);
    send_load(4321, 1'b1);
    send_ticks(1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       period = 16'd1;
        1:       period = '0;
        2:       period = 16'd3;
        3:       period = '1;
        4:       period = PERIOD_W'($urandom_range(0, 7));
        5:       period = 16'd2;
        6:       period = PERIOD_W'($urandom_range(0, 15));
        default: period = '0;
      endcase
      set_period(period);
      calm  = (ph % 3 == 2);
      count = (period == '1) ? 20 : 130;
      repeat (count) send_item(random_item((period == '0) ? 60 : 80));
    end

    in_valid <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d loads and %0d ticks under %0d refresh period settings (0 to 65535).",
             loads_sent, ticks_sent, periods_used);
    $display("Checked %0d refresh beats against the predicted digit scan.", beats_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/svmd_pkg.sv
hw/rtl/svmd_split.sv
hw/rtl/svmd_refresh.sv
hw/rtl/seven_segment_mux_driver.sv
hw/rtl/svmd_checker.sv
dv/svmd_checker.sv
dv/tb_top.sv
